FILE: rtl/ihb_pkg.sv
// types and constants shared by the ipv4 header builder modules
package ihb_pkg;

	localparam int HDR_LEN = 20;
	localparam int IDX_W = $clog2(HDR_LEN);
	localparam int SUM_W = 19;

	localparam logic [7:0] VER_IHL = 8'h45;
	localparam logic [7:0] TTL_VAL = 8'd64;
	localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LEN = 2'd1;
	localparam logic [1:0] ST_STRAY = 2'd2;

	typedef enum logic [1:0] {
		K_HDR,
		K_DATA,
		K_ERR_LEN,
		K_ERR_STRAY
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [15:0] tot_len;
		logic [7:0] protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [SUM_W-1:0] sum;
		logic [7:0] data;
		logic last;
		logic route;
	} cmd_t;

endpackage

FILE: rtl/ihb_front.sv
// front end: accepts words, tracks the open packet and queues commands
module ihb_front #(
	parameter int MAX_PACKET = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic req_type,
	input logic [7:0] protocol,
	input logic [31:0] src_addr,
	input logic [31:0] dst_addr,
	input logic [15:0] payload_len,
	input logic [7:0] data_byte,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data,
	input logic q_full,
	output logic push,
	output ihb_pkg::cmd_t push_cmd
);

	logic [31:0] local_addr_q;
	logic [15:0] bytes_left_q;
	logic packet_open_q;
	logic route_held_q;

	logic [16:0] tot_len;
	logic oversize;
	logic rt;
	logic [ihb_pkg::SUM_W-1:0] sum;
	logic accept;

	assign item_ready = !q_full;
	assign cfg_ready = 1'b1;
	assign accept = item_valid && item_ready;
	assign push = accept;

	assign tot_len = 17'(payload_len) + 17'(ihb_pkg::HDR_LEN);
	assign oversize = tot_len > 17'(MAX_PACKET);
	assign rt = (dst_addr == local_addr_q) && (dst_addr == ihb_pkg::LOOPBACK_ADDR);

	// header words, checksum field taken as zero
	assign sum = ihb_pkg::SUM_W'({ihb_pkg::VER_IHL, 8'h00})
		+ ihb_pkg::SUM_W'(tot_len[15:0])
		+ ihb_pkg::SUM_W'({ihb_pkg::TTL_VAL, protocol})
		+ ihb_pkg::SUM_W'(src_addr[31:16]) + ihb_pkg::SUM_W'(src_addr[15:0])
		+ ihb_pkg::SUM_W'(dst_addr[31:16]) + ihb_pkg::SUM_W'(dst_addr[15:0]);

	always_comb begin
		push_cmd = '0;
		push_cmd.tot_len = tot_len[15:0];
		push_cmd.protocol = protocol;
		push_cmd.src_addr = src_addr;
		push_cmd.dst_addr = dst_addr;
		push_cmd.sum = sum;
		push_cmd.data = data_byte;
		if (req_type == ihb_pkg::REQ_START) begin
			if (oversize) begin
				push_cmd.kind = ihb_pkg::K_ERR_LEN;
			end else begin
				push_cmd.kind = ihb_pkg::K_HDR;
				push_cmd.last = payload_len == 16'd0;
				push_cmd.route = rt;
			end
		end else if (!packet_open_q) begin
			push_cmd.kind = ihb_pkg::K_ERR_STRAY;
		end else begin
			push_cmd.kind = ihb_pkg::K_DATA;
			push_cmd.last = bytes_left_q == 16'd1;
			push_cmd.route = route_held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_addr_q <= '0;
			bytes_left_q <= '0;
			packet_open_q <= 1'b0;
			route_held_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				local_addr_q <= cfg_data;
			end
			if (accept) begin
				if (req_type == ihb_pkg::REQ_START) begin
					if (oversize) begin
						bytes_left_q <= '0;
						packet_open_q <= 1'b0;
					end else begin
						bytes_left_q <= payload_len;
						packet_open_q <= payload_len != 16'd0;
						route_held_q <= rt;
					end
				end else if (packet_open_q) begin
					bytes_left_q <= bytes_left_q - 16'd1;
					if (bytes_left_q == 16'd1) begin
						packet_open_q <= 1'b0;
					end
				end
			end
		end
	end

	a_open_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		packet_open_q == (bytes_left_q != 16'd0))
		else $error("open flag and byte count disagree");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");

endmodule

FILE: rtl/ihb_queue.sv
// command queue between front and back
module ihb_queue #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ihb_pkg::cmd_t wr_cmd,
	output logic full,
	input logic pop,
	output ihb_pkg::cmd_t rd_cmd,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ihb_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count overflow");

endmodule

FILE: rtl/ihb_back.sv
// back end: expands queued commands into output words
module ihb_back (
	input logic clk,
	input logic arst_n,
	input ihb_pkg::cmd_t rd_cmd,
	input logic empty,
	output logic pop,
	output logic res_valid,
	input logic res_ready,
	output logic [7:0] out_byte,
	output logic is_last,
	output logic route,
	output logic [1:0] status
);

	logic [ihb_pkg::IDX_W-1:0] idx_q;
	logic res_valid_q;
	logic [7:0] byte_q;
	logic last_q;
	logic route_q;
	logic [1:0] status_q;

	logic load;
	logic go;
	logic hdr_end;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic [15:0] ck;
	logic [7:0] hdr_byte;
	logic [7:0] nxt_byte;
	logic nxt_last;
	logic nxt_route;
	logic [1:0] nxt_status;
	logic done;

	assign res_valid = res_valid_q;
	assign out_byte = byte_q;
	assign is_last = last_q;
	assign route = route_q;
	assign status = status_q;

	assign load = !res_valid_q || res_ready;
	assign go = load && !empty;
	assign hdr_end = idx_q == ihb_pkg::IDX_W'(ihb_pkg::HDR_LEN - 1);
	assign pop = go && done;

	// ones-complement carry fold
	assign fold1 = 17'(rd_cmd.sum[15:0]) + 17'(rd_cmd.sum[ihb_pkg::SUM_W-1:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);
	assign ck = ~fold2;

	always_comb begin
		case (idx_q)
			5'd0: hdr_byte = ihb_pkg::VER_IHL;
			5'd2: hdr_byte = rd_cmd.tot_len[15:8];
			5'd3: hdr_byte = rd_cmd.tot_len[7:0];
			5'd8: hdr_byte = ihb_pkg::TTL_VAL;
			5'd9: hdr_byte = rd_cmd.protocol;
			5'd10: hdr_byte = ck[15:8];
			5'd11: hdr_byte = ck[7:0];
			5'd12: hdr_byte = rd_cmd.src_addr[31:24];
			5'd13: hdr_byte = rd_cmd.src_addr[23:16];
			5'd14: hdr_byte = rd_cmd.src_addr[15:8];
			5'd15: hdr_byte = rd_cmd.src_addr[7:0];
			5'd16: hdr_byte = rd_cmd.dst_addr[31:24];
			5'd17: hdr_byte = rd_cmd.dst_addr[23:16];
			5'd18: hdr_byte = rd_cmd.dst_addr[15:8];
			5'd19: hdr_byte = rd_cmd.dst_addr[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	always_comb begin
		nxt_byte = 8'h00;
		nxt_last = 1'b0;
		nxt_route = 1'b0;
		nxt_status = ihb_pkg::ST_OK;
		done = 1'b1;
		case (rd_cmd.kind)
			ihb_pkg::K_HDR: begin
				nxt_byte = hdr_byte;
				nxt_last = rd_cmd.last && hdr_end;
				nxt_route = rd_cmd.route;
				done = hdr_end;
			end
			ihb_pkg::K_DATA: begin
				nxt_byte = rd_cmd.data;
				nxt_last = rd_cmd.last;
				nxt_route = rd_cmd.route;
			end
			ihb_pkg::K_ERR_LEN: begin
				nxt_status = ihb_pkg::ST_LEN;
			end
			ihb_pkg::K_ERR_STRAY: begin
				nxt_status = ihb_pkg::ST_STRAY;
			end
			default: begin
				nxt_status = ihb_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_q <= nxt_byte;
			last_q <= nxt_last;
			route_q <= nxt_route;
			status_q <= nxt_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				res_valid_q <= !empty;
			end
			if (go) begin
				idx_q <= done ? '0 : idx_q + 1'b1;
			end
		end
	end

	a_last_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && last_q |-> status_q == ihb_pkg::ST_OK)
		else $error("last word with error status");

	a_mid_header_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> !empty && rd_cmd.kind == ihb_pkg::K_HDR)
		else $error("header position set without header command");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= ihb_pkg::IDX_W'(ihb_pkg::HDR_LEN - 1))
		else $error("header position out of range");

endmodule

FILE: rtl/ipv4_header_builder.sv
// top level of the ipv4 header builder
//
//  channel  signals                      direction  payload
//  item     item_valid / item_ready      in         req_type protocol src_addr dst_addr
//                                                   payload_len data_byte
//  result   res_valid / res_ready        out        out_byte is_last route status
//  config   cfg_valid / cfg_ready        in         cfg_data (local_addr)
//
// a start word yields 20 result words, or one error word if the packet exceeds MAX_PACKET
// payload and error words yield one result word each, one per cycle while the output is not stalled
// the front takes a word per cycle while the command queue has room
// results sit in one output register; a stall there fills the queue, then holds off items
// arst_n clears the local address, packet tracking, queue and output valid
module ipv4_header_builder #(
	parameter int MAX_PACKET = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input logic req_type,
	input logic [7:0] protocol,
	input logic [31:0] src_addr,
	input logic [31:0] dst_addr,
	input logic [15:0] payload_len,
	input logic [7:0] data_byte,
	output logic res_valid,
	input logic res_ready,
	output logic [7:0] out_byte,
	output logic is_last,
	output logic route,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [31:0] cfg_data
);

	ihb_pkg::cmd_t push_cmd;
	ihb_pkg::cmd_t rd_cmd;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	ihb_front #(
		.MAX_PACKET(MAX_PACKET)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.req_type(req_type),
		.protocol(protocol),
		.src_addr(src_addr),
		.dst_addr(dst_addr),
		.payload_len(payload_len),
		.data_byte(data_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd)
	);

	ihb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_cmd(push_cmd),
		.full(q_full),
		.pop(pop),
		.rd_cmd(rd_cmd),
		.empty(q_empty)
	);

	ihb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rd_cmd(rd_cmd),
		.empty(q_empty),
		.pop(pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_byte(out_byte),
		.is_last(is_last),
		.route(route),
		.status(status)
	);

endmodule

FILE: test/tb_ipv4_header_builder.sv
// self-checking testbench for the ipv4 header builder
`timescale 1ns / 100ps

module tb_ipv4_header_builder;

	localparam int MAX_PACKET = 1024;
	localparam int MAX_PLEN = MAX_PACKET - ihb_pkg::HDR_LEN;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic req;
		logic [7:0] proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] plen;
		logic [7:0] db;
	} in_word_t;

	typedef struct packed {
		logic [7:0] b;
		logic last;
		logic rt;
		logic [1:0] st;
	} out_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic req_type = ihb_pkg::REQ_START;
	logic [7:0] protocol = '0;
	logic [31:0] src_addr = '0;
	logic [31:0] dst_addr = '0;
	logic [15:0] payload_len = '0;
	logic [7:0] data_byte = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic [7:0] out_byte;
	logic is_last;
	logic route;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	in_word_t pending[$];
	out_word_t bytes_due[$];
	in_word_t seen_word;
	out_word_t due;
	logic word_taken = 1'b0;
	int n_queued = 0;
	int n_accepted = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// mirror of the block state
	logic [31:0] local_m = '0;
	logic [15:0] left_m = '0;
	logic open_m = 1'b0;
	logic route_m = 1'b0;

	ipv4_header_builder #(
		.MAX_PACKET(MAX_PACKET)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.req_type(req_type),
		.protocol(protocol),
		.src_addr(src_addr),
		.dst_addr(dst_addr),
		.payload_len(payload_len),
		.data_byte(data_byte),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.out_byte(out_byte),
		.is_last(is_last),
		.route(route),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic frame_word(input in_word_t w);
		logic [7:0] hdr [ihb_pkg::HDR_LEN];
		logic [31:0] tot;
		logic [31:0] acc;
		logic [15:0] ck;
		logic rt;
		int i;
		if (w.req == ihb_pkg::REQ_START) begin
			open_m = 1'b0;
			left_m = '0;
			tot = 32'(ihb_pkg::HDR_LEN) + 32'(w.plen);
			if (tot > MAX_PACKET) begin
				bytes_due.push_back({8'h00, 1'b0, 1'b0, ihb_pkg::ST_LEN});
				return;
			end
			rt = (w.dst == local_m) && (w.dst == ihb_pkg::LOOPBACK_ADDR);
			for (i = 0; i < ihb_pkg::HDR_LEN; i++)
				hdr[i] = 8'h00;
			hdr[0] = ihb_pkg::VER_IHL;
			hdr[2] = tot[15:8];
			hdr[3] = tot[7:0];
			hdr[8] = ihb_pkg::TTL_VAL;
			hdr[9] = w.proto;
			for (i = 0; i < 4; i++) begin
				hdr[12 + i] = w.src[31 - 8 * i -: 8];
				hdr[16 + i] = w.dst[31 - 8 * i -: 8];
			end
			// ones-complement sum, folded until no carry is left
			acc = '0;
			for (i = 0; i < ihb_pkg::HDR_LEN; i += 2)
				acc = acc + {16'h0000, hdr[i], hdr[i + 1]};
			while (acc[31:16] != 0)
				acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
			ck = ~acc[15:0];
			hdr[10] = ck[15:8];
			hdr[11] = ck[7:0];
			for (i = 0; i < ihb_pkg::HDR_LEN; i++)
				bytes_due.push_back({hdr[i],
					(i == ihb_pkg::HDR_LEN - 1) && (w.plen == 0), rt, ihb_pkg::ST_OK});
			route_m = rt;
			left_m = w.plen;
			open_m = (w.plen != 0);
		end else if (!open_m) begin
			bytes_due.push_back({8'h00, 1'b0, 1'b0, ihb_pkg::ST_STRAY});
		end else begin
			left_m = left_m - 16'd1;
			bytes_due.push_back({w.db, left_m == 0, route_m, ihb_pkg::ST_OK});
			if (left_m == 0)
				open_m = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input out_word_t e, input out_word_t a, input logic stray);
		mismatches++;
		if (mismatches <= 10) begin
			if (stray)
				$display("unexpected word: byte %02h last %0d route %0d status %0d",
					a.b, a.last, a.rt, a.st);
			else
				$display("mismatch: exp byte %02h last %0d route %0d status %0d,",
					e.b, e.last, e.rt, e.st,
					" got byte %02h last %0d route %0d status %0d",
					a.b, a.last, a.rt, a.st);
		end
	endtask

	// driver and ready generator
	always @(negedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || word_taken) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				seen_word = pending.pop_front();
				req_type <= seen_word.req;
				protocol <= seen_word.proto;
				src_addr <= seen_word.src;
				dst_addr <= seen_word.dst;
				payload_len <= seen_word.plen;
				data_byte <= seen_word.db;
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// monitor, predictor hookup and watchdog
	always @(posedge clk) begin
		word_taken <= arst_n && item_valid && item_ready;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				frame_word({req_type, protocol, src_addr, dst_addr, payload_len, data_byte});
				n_accepted++;
			end
			if (cfg_valid && cfg_ready)
				local_m = cfg_data;
			if (res_valid && res_ready) begin
				if (bytes_due.size() == 0) begin
					flag_mismatch('0, {out_byte, is_last, route, status}, 1'b1);
				end else begin
					due = bytes_due.pop_front();
					if (due != {out_byte, is_last, route, status})
						flag_mismatch(due, {out_byte, is_last, route, status}, 1'b0);
				end
			end
			if ((item_valid && item_ready) || (res_valid && res_ready)
				|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	task automatic queue_item(input logic req, input logic [7:0] proto, input logic [31:0] src,
		input logic [31:0] dst, input logic [15:0] plen, input logic [7:0] db);
		pending.push_back({req, proto, src, dst, plen, db});
		n_queued++;
	endtask

	task automatic queue_random(input int n, input logic [31:0] lcl);
		int added;
		int r;
		int k;
		int plen;
		int cut;
		logic [31:0] dst;
		added = 0;
		while (added < n) begin
			r = $urandom_range(99);
			k = $urandom_range(9);
			dst = (k < 4) ? ihb_pkg::LOOPBACK_ADDR : (k < 6) ? lcl : $urandom;
			if (r < 72) begin
				k = $urandom_range(9);
				plen = (k < 6) ? $urandom_range(6) : (k < 9) ? $urandom_range(40, 7) : 0;
				// now and then cut the packet short so the next start abandons it
				cut = ($urandom_range(9) == 0) ? $urandom_range(plen) : plen;
				queue_item(ihb_pkg::REQ_START, 8'($urandom), $urandom, dst, 16'(plen),
					8'($urandom));
				for (k = 0; k < cut; k++)
					queue_item(ihb_pkg::REQ_DATA, 8'($urandom), $urandom, $urandom,
						16'($urandom), 8'($urandom));
				added += 1 + cut;
			end else if (r < 82) begin
				queue_item(ihb_pkg::REQ_START, 8'($urandom), $urandom, dst,
					16'($urandom_range(16'hFFFF, MAX_PLEN + 1)), 8'($urandom));
				added++;
			end else begin
				queue_item(ihb_pkg::REQ_DATA, 8'($urandom), $urandom, $urandom,
					16'($urandom), 8'($urandom));
				added++;
			end
		end
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (n_accepted != n_queued || bytes_due.size() != 0);
	endtask

	task automatic write_local(input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] lcl, input int send_pct, input int stall_pct,
		input int n);
		write_local(lcl);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		queue_random(n, lcl);
		drain();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words, local address still at reset value
		queue_item(ihb_pkg::REQ_START, 8'h00, 32'h0000_0000, 32'h0000_0000, 16'd0, 8'hFF);
		queue_item(ihb_pkg::REQ_START, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 8'h00);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'hFF);
		queue_item(ihb_pkg::REQ_START, 8'h06, 32'hC0A8_0001, ihb_pkg::LOOPBACK_ADDR,
			16'(MAX_PLEN), 8'h00);
		queue_item(ihb_pkg::REQ_DATA, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h00);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'hFF);
		queue_item(ihb_pkg::REQ_START, 8'h11, 32'h0A00_0001, 32'h0A00_0002, 16'd3, 8'h00);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'hA5);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'h5A);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'hFF);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'h3C);
		queue_item(ihb_pkg::REQ_START, 8'h01, 32'h0101_0101, 32'h0202_0202,
			16'(MAX_PLEN + 1), 8'h00);
		queue_item(ihb_pkg::REQ_START, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'h11);
		queue_item(ihb_pkg::REQ_START, 8'h01, 32'h7F00_0001, ihb_pkg::LOOPBACK_ADDR, 16'd1,
			8'h00);
		queue_item(ihb_pkg::REQ_DATA, 8'h00, 32'h0, 32'h0, 16'h0, 8'h80);
		queue_random(20, 32'h0000_0000);
		drain();

		run_phase(ihb_pkg::LOOPBACK_ADDR, 67, 0, 45);
		run_phase(32'hFFFF_FFFF, 0, 67, 45);
		run_phase($urandom, 14, 14, 35);
		run_phase(ihb_pkg::LOOPBACK_ADDR, 0, 0, 35);
		run_phase(32'h0000_0000, 0, 67, 15);

		repeat (TAIL_CYCLES) @(posedge clk);
		#1;
		if (mismatches == 0 && bytes_due.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/ihb_pkg.sv
rtl/ihb_front.sv
rtl/ihb_queue.sv
rtl/ihb_back.sv
rtl/ipv4_header_builder.sv
test/tb_ipv4_header_builder.sv
